// ===== src/sirt_pkg.sv =====
// Shared types, constants and the digit alphabet for the radix text converter.
// No dependencies.
package sirt_pkg;

	// bits retired per cycle by the shared divider
	localparam int DIV_STEPS = 8;

	localparam logic [5:0] RADIX_RESET = 6'd10;
	localparam logic [5:0] RADIX_MIN   = 6'd2;
	localparam logic [5:0] RADIX_MAX   = 6'd62;
	localparam logic [5:0] DEC_DIGITS  = 6'd10;
	localparam logic [5:0] CASE_SPLIT  = 6'd36;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_UC_A  = 8'h41;
	localparam logic [7:0] CH_LC_A  = 8'h61;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_SIGN,
		ST_RD,
		ST_LD
	} state_t;

	// 0-9, then a-z up to base 36; above that 0-9, A-Z, a-z
	function automatic logic [7:0] digit_char(input logic [5:0] dv, input logic [5:0] base);
		logic [7:0] d;
		d = {2'b00, dv};
		if (dv < DEC_DIGITS)
			return CH_ZERO + d;
		else if (base <= CASE_SPLIT)
			return CH_LC_A + d - {2'b00, DEC_DIGITS};
		else if (dv < CASE_SPLIT)
			return CH_UC_A + d - {2'b00, DEC_DIGITS};
		else
			return CH_LC_A + d - {2'b00, CASE_SPLIT};
	endfunction

endpackage

// ===== src/sirt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sirt_ram #(
	parameter int WIDTH = 6,
	parameter int DEPTH = 62
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule

// ===== src/sirt_div.sv =====
// Iterative restoring divider: wide dividend by a 6-bit divisor, DIV_STEPS bits a cycle.
// Depends on sirt_pkg.
module sirt_div #(
	parameter int DIV_W = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] dividend,
	input  logic [5:0]       divisor,
	output logic             done,
	output logic [DIV_W-1:0] quotient,
	output logic [5:0]       remainder
);

	import sirt_pkg::*;

	localparam int NCYC  = DIV_W / DIV_STEPS;
	localparam int CNT_W = (NCYC > 1) ? $clog2(NCYC) : 1;

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0] acc_q;
	logic [5:0]       rem_q;
	logic [DIV_W-1:0] acc_nx;
	logic [5:0]       rem_nx;

	// shift dividend bits out of the top, quotient bits in at the bottom
	always_comb begin
		logic [6:0] t;
		acc_nx = acc_q;
		rem_nx = rem_q;
		t = '0;
		for (int i = 0; i < DIV_STEPS; i++) begin
			t = {rem_nx, acc_nx[DIV_W-1]};
			acc_nx = {acc_nx[DIV_W-2:0], 1'b0};
			if (t >= {1'b0, divisor}) begin
				t = t - {1'b0, divisor};
				acc_nx[0] = 1'b1;
			end
			rem_nx = t[5:0];
		end
	end

	assign done      = busy_q && (cnt_q == CNT_W'(NCYC - 1));
	assign quotient  = acc_nx;
	assign remainder = rem_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_nx;
			rem_q <= rem_nx;
		end
	end

endmodule

// ===== src/signed_integer_to_radix_text_core.sv =====
// Signed integer to ASCII text in a configurable base (2..62), one character per output transfer.
// Depends on sirt_pkg, sirt_div and sirt_ram.
//
// Usage:
//   Input channel in_valid/in_ready/value takes one 63-bit two's complement integer.
//   Output channel out_valid/out_ready/character/last gives a leading '-' for a
//   negative value, then the digits most significant first; last marks the final digit.
//   cfg_wr_en/cfg_wr_data write the radix (0 and 1 act as 2, 63 acts as 62); write it
//   only while no number is in flight. Magnitudes wider than min(VALUE_BITS,62) bits saturate.
// Operation:
//   in_ready is high only between numbers. Digits come from the shared divider, which
//   retires 8 dividend bits a cycle, one full division per digit. Digits are parked in
//   a small RAM; each character is then read from the RAM (ST_RD) and loaded into the
//   output register (ST_LD).
// Reset clears the control and the radix (to 10); the digit RAM needs no clearing.
// A stalled receiver holds the output register; the sequencer waits and loses nothing.
// The next number is taken while the final character still waits in the output register.
module signed_integer_to_radix_text_core #(
	parameter int VALUE_BITS = 62
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [5:0]  cfg_wr_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic signed [62:0] value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  character,
	output logic        last
);

	import sirt_pkg::*;

	localparam int MAG_W = (VALUE_BITS > 62) ? 62 : VALUE_BITS;
	localparam int DIV_W = ((MAG_W + DIV_STEPS - 1) / DIV_STEPS) * DIV_STEPS;
	localparam int DEPTH = MAG_W;
	localparam int IDX_W = $clog2(DEPTH);
	localparam logic [62:0] MAG_MAX = (63'd1 << MAG_W) - 63'd1;

	state_t state_q, state_nx;

	logic [5:0]       radix_q;
	logic [5:0]       base_q;
	logic             neg_q;
	logic [IDX_W-1:0] wr_idx_q;
	logic [IDX_W-1:0] rd_idx_q;
	logic             out_valid_q;
	logic [7:0]       char_q;
	logic             last_q;

	logic [62:0]      v_mag;
	logic [MAG_W-1:0] mag_sat;
	logic [5:0]       base_in;
	logic             in_take;
	logic             out_free;

	logic             div_start;
	logic [DIV_W-1:0] div_dividend;
	logic             div_done;
	logic [DIV_W-1:0] div_quot;
	logic [5:0]       div_rem;
	logic             ram_we;
	logic [5:0]       ram_rdata;

	logic             more_digits;
	logic             load_out;
	logic [7:0]       load_char;
	logic             load_last;

	assign v_mag    = value[62] ? 63'(-value) : 63'(value);
	assign mag_sat  = (v_mag > MAG_MAX) ? {MAG_W{1'b1}} : v_mag[MAG_W-1:0];
	assign base_in  = (radix_q < RADIX_MIN) ? RADIX_MIN :
	                  (radix_q > RADIX_MAX) ? RADIX_MAX : radix_q;
	assign in_take  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign more_digits = (div_quot != '0) && (wr_idx_q != IDX_W'(DEPTH - 1));

	sirt_div #(
		.DIV_W(DIV_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (base_q),
		.done      (div_done),
		.quotient  (div_quot),
		.remainder (div_rem)
	);

	sirt_ram #(
		.WIDTH(6),
		.DEPTH(DEPTH)
	) u_digits (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wr_idx_q),
		.wdata (div_rem),
		.raddr (rd_idx_q),
		.rdata (ram_rdata)
	);

	always_comb begin
		state_nx     = state_q;
		in_ready     = 1'b0;
		div_start    = 1'b0;
		div_dividend = div_quot;
		ram_we       = 1'b0;
		load_out     = 1'b0;
		load_char    = digit_char(ram_rdata, base_q);
		load_last    = (rd_idx_q == '0);
		unique case (state_q)
			ST_IDLE: begin
				in_ready     = 1'b1;
				div_dividend = DIV_W'(mag_sat);
				if (in_valid) begin
					div_start = 1'b1;
					state_nx  = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					ram_we = 1'b1;
					if (more_digits)
						div_start = 1'b1;
					else
						state_nx = neg_q ? ST_SIGN : ST_RD;
				end
			end
			ST_SIGN: begin
				load_char = CH_MINUS;
				load_last = 1'b0;
				if (out_free) begin
					load_out = 1'b1;
					state_nx = ST_RD;
				end
			end
			ST_RD: begin
				state_nx = ST_LD;
			end
			ST_LD: begin
				if (out_free) begin
					load_out = 1'b1;
					state_nx = (rd_idx_q == '0) ? ST_IDLE : ST_RD;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			radix_q     <= RADIX_RESET;
			out_valid_q <= 1'b0;
			wr_idx_q    <= '0;
			rd_idx_q    <= '0;
		end else begin
			state_q <= state_nx;
			if (cfg_wr_en)
				radix_q <= cfg_wr_data;
			if (load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			if (in_take)
				wr_idx_q <= '0;
			else if (ram_we && more_digits)
				wr_idx_q <= wr_idx_q + IDX_W'(1);
			if (ram_we && !more_digits)
				rd_idx_q <= wr_idx_q;
			else if (state_q == ST_LD && load_out && rd_idx_q != '0)
				rd_idx_q <= rd_idx_q - IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			neg_q  <= value[62];
			base_q <= base_in;
		end
		if (load_out) begin
			char_q <= load_char;
			last_q <= load_last;
		end
	end

	assign out_valid = out_valid_q;
	assign character = char_q;
	assign last      = last_q;

`ifndef NO_ASSERTIONS
	a_rem_below_base: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (div_rem < base_q))
		else $error("divider remainder not below base");

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("divider finished outside digit loop");

	a_sign_only_neg: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SIGN) |-> neg_q)
		else $error("sign emitted for non-negative item");

	a_last_ends_item: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && load_last) |=> (state_q == ST_IDLE))
		else $error("final character loaded but sequencer not idle");
`endif

endmodule

// ===== sim/signed_integer_to_radix_text_core_test.sv =====
// Self-checking bench for signed_integer_to_radix_text_core: directed and random numbers
// over a range of radix settings, with each output character checked against a predictor.
// Depends on sirt_pkg and the core RTL.
`timescale 1ns / 100ps

module signed_integer_to_radix_text_core_test;
	import sirt_pkg::*;

	localparam int VALUE_BITS = 62;
	localparam int HOLD_LEN = 400;
	localparam int LIMIT = 3000000;
	localparam int PHASE_ITEMS = 12;
	localparam logic signed [62:0] MAG_MAX = 63'h3FFF_FFFF_FFFF_FFFF;
	localparam logic signed [62:0] MOST_NEG = 63'h4000_0000_0000_0000;
	localparam logic [5:0] SCHEDULE [10] = '{6'd2, 6'd62, 6'd36, 6'd37, 6'd16,
		6'd0, 6'd1, 6'd63, 6'd8, RADIX_RESET};

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [5:0] cfg_wr_data;
	logic in_valid;
	logic in_ready;
	logic signed [62:0] value;
	logic out_valid;
	logic out_ready;
	logic [7:0] character;
	logic last;

	int cycle_count = 0;
	bit tx_calm;
	bit rx_calm;
	bit hold_req;
	int rx_wait;
	int hold_cnt;

	class radix_text_board;
		logic [5:0] radix;
		logic [7:0] expected_chars[$];
		logic expected_last[$];
		int errors;

		function new();
			radix = RADIX_RESET;
			errors = 0;
		endfunction

		function int outstanding();
			return expected_chars.size();
		endfunction

		function logic [7:0] glyph(input logic [5:0] dv, input logic [5:0] base);
			logic [7:0] d;
			d = {2'b00, dv};
			if (dv < DEC_DIGITS)
				return CH_ZERO + d;
			if (base <= CASE_SPLIT)
				return CH_LC_A + d - {2'b00, DEC_DIGITS};
			if (dv < CASE_SPLIT)
				return CH_UC_A + d - {2'b00, DEC_DIGITS};
			return CH_LC_A + d - {2'b00, CASE_SPLIT};
		endfunction

		// expected characters for one accepted number
		function void note_number(input logic signed [62:0] v);
			logic [62:0] mag;
			logic [62:0] wide_base;
			logic [5:0] base;
			logic [5:0] digs [62];
			bit neg;
			int n;
			neg = v[62];
			mag = neg ? (~v + 63'd1) : v;
			if (mag > MAG_MAX)
				mag = MAG_MAX;
			base = radix;
			if (base < RADIX_MIN)
				base = RADIX_MIN;
			if (base > RADIX_MAX)
				base = RADIX_MAX;
			wide_base = {57'd0, base};
			n = 0;
			do begin
				digs[n] = 6'(mag % wide_base);
				mag = mag / wide_base;
				n++;
			end while (mag != 0 && n < 62);
			if (neg && !(n == 1 && digs[0] == 6'd0)) begin
				expected_chars.push_back(CH_MINUS);
				expected_last.push_back(1'b0);
			end
			for (int i = n - 1; i >= 0; i--) begin
				expected_chars.push_back(glyph(digs[i], base));
				expected_last.push_back(i == 0);
			end
		endfunction

		task report(input string msg);
			if (errors < 40)
				$display("%0t: mismatch: %s", $time, msg);
			errors++;
		endtask

		task check_char(input logic [7:0] got_char, input logic got_last);
			logic [7:0] want_char;
			logic want_last;
			if (expected_chars.size() == 0) begin
				report($sformatf("character %h with nothing expected", got_char));
			end else begin
				want_char = expected_chars.pop_front();
				want_last = expected_last.pop_front();
				if (got_char !== want_char)
					report($sformatf("character %h, want %h", got_char, want_char));
				if (got_last !== want_last)
					report($sformatf("last %b, want %b", got_last, want_last));
			end
		endtask
	endclass

	radix_text_board board = new();

	signed_integer_to_radix_text_core #(
		.VALUE_BITS(VALUE_BITS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.value(value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.character(character),
		.last(last)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count == LIMIT);
		$display("FAIL signed_integer_to_radix_text_core");
		$finish;
	end

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic signed [62:0] rand_value(input logic [5:0] raw_radix);
		logic signed [62:0] v;
		logic [62:0] p;
		logic [62:0] b;
		int w;
		b = (raw_radix < RADIX_MIN) ? 63'(RADIX_MIN) :
			(raw_radix > RADIX_MAX) ? 63'(RADIX_MAX) : 63'(raw_radix);
		case ($urandom_range(0, 9))
			0, 1: v = 63'($urandom_range(0, 4000));
			2, 3, 4: v = 63'({$urandom, $urandom});
			5, 6: begin
				w = $urandom_range(1, 62);
				v = 63'({$urandom, $urandom});
				v = v & ((63'd1 << w) - 63'd1);
			end
			7: begin
				case ($urandom_range(0, 5))
					0: v = '0;
					1: v = 63'sd1;
					2: v = -63'sd1;
					3: v = MAG_MAX;
					4: v = -MAG_MAX;
					default: v = MOST_NEG;
				endcase
			end
			default: begin
				// near a power of the base, where the digit count changes
				p = 63'd1;
				w = $urandom_range(1, 61);
				repeat (w) begin
					if (p <= MAG_MAX / b)
						p = p * b;
				end
				v = p + 63'($urandom_range(0, 2)) - 63'd1;
			end
		endcase
		if ($urandom_range(0, 1) == 1)
			v = -v;
		return v;
	endfunction

	task automatic offer_number(input logic signed [62:0] v);
		int gap;
		gap = tx_calm ? 0 : idle_len();
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		value = v;
		do @(posedge clk); while (in_ready !== 1'b1);
		board.note_number(v);
	endtask

	task automatic quiesce();
		@(negedge clk);
		in_valid = 1'b0;
		while (board.outstanding() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_radix(input logic [5:0] r);
		quiesce();
		@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_wr_data = r;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		board.radix = r;
	endtask

	// receiver: random stalls, calm stretches and one long hold-off
	initial begin
		out_ready = 1'b0;
		rx_wait = 0;
		hold_cnt = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready = 1'b0;
				hold_cnt++;
				if (hold_cnt == HOLD_LEN) begin
					hold_req = 1'b0;
					hold_cnt = 0;
				end
			end else if (rx_wait > 0) begin
				out_ready = 1'b0;
				rx_wait--;
			end else begin
				out_ready = 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
			board.check_char(character, last);
			rx_wait = rx_calm ? 0 : idle_len();
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = RADIX_RESET;
		in_valid = 1'b0;
		value = '0;
		tx_calm = 1'b0;
		rx_calm = 1'b0;
		hold_req = 1'b0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// decimal at reset: extremes, sign handling and saturation
		offer_number(63'sd0);
		offer_number(63'sd1);
		offer_number(-63'sd1);
		offer_number(63'sd9);
		offer_number(-63'sd9);
		offer_number(63'sd10);
		offer_number(-63'sd10);
		offer_number(MAG_MAX);
		offer_number(-MAG_MAX);
		offer_number(MOST_NEG);
		offer_number(63'h2AAA_AAAA_AAAA_AAAA);
		offer_number(63'h5555_5555_5555_5555);
		offer_number(63'sd12345);
		offer_number(-63'sd987654321);

		foreach (SCHEDULE[i]) begin
			set_radix(SCHEDULE[i]);
			if (SCHEDULE[i] == RADIX_MAX) begin
				// alphabet seams above base 36
				offer_number(63'sd9);
				offer_number(63'sd10);
				offer_number(63'sd35);
				offer_number(63'sd36);
				offer_number(63'sd61);
				offer_number(63'sd62);
				offer_number(-63'sd61);
			end
			if (SCHEDULE[i] == CASE_SPLIT) begin
				offer_number(63'sd35);
				offer_number(63'sd36);
			end
			tx_calm = (i % 3 == 0);
			rx_calm = (i % 4 == 1);
			repeat (PHASE_ITEMS) offer_number(rand_value(SCHEDULE[i]));
		end

		// long receiver hold-off while items keep coming, so the input backs up
		set_radix(6'd16);
		tx_calm = 1'b1;
		rx_calm = 1'b0;
		hold_req = 1'b1;
		repeat (8) offer_number(rand_value(6'd16));
		tx_calm = 1'b0;

		repeat (2) begin
			set_radix(6'($urandom_range(0, 63)));
			repeat (8) offer_number(rand_value(board.radix));
		end

		quiesce();
		repeat (30) @(posedge clk);
		if (board.outstanding() != 0)
			board.report($sformatf("%0d characters never arrived", board.outstanding()));
		if (board.errors == 0)
			$display("PASS signed_integer_to_radix_text_core");
		else
			$display("FAIL signed_integer_to_radix_text_core");
		$finish;
	end

endmodule

// ===== signed_integer_to_radix_text_core.f =====
src/sirt_pkg.sv
src/sirt_ram.sv
src/sirt_div.sv
src/signed_integer_to_radix_text_core.sv
sim/signed_integer_to_radix_text_core_test.sv
